>>> design/tchi_pkg.sv
// Shared types, codes and constants for the tape controller host interface.
package tchi_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned REG_W   = 2;
    localparam int unsigned CFG_W   = 3;
    localparam int unsigned IN_DW   = 48;
    localparam int unsigned IN_UW   = 4;
    localparam int unsigned OUT_DW  = 16;

    typedef enum logic [3:0] {
        ACT_READ      = 4'd0,
        ACT_WRITE     = 4'd1,
        ACT_ADVANCE   = 4'd2,
        ACT_CMD_ACC   = 4'd3,
        ACT_BYTE_TKN  = 4'd4,
        ACT_REQ_REL   = 4'd5,
        ACT_BLOCK     = 4'd6,
        ACT_DMA_TC    = 4'd7,
        ACT_SET_EXC   = 4'd8,
        ACT_SET_DIR   = 4'd9
    } t_action;

    typedef enum logic [REG_W-1:0] {
        REG_DATA    = 2'd0,
        REG_CTRL    = 2'd1,
        REG_DMA_GO  = 2'd2,
        REG_DMA_RST = 2'd3
    } t_reg;

    typedef enum logic [CFG_W-1:0] {
        CFG_CMD_EXEC  = 3'd0,
        CFG_EXC_READY = 3'd1,
        CFG_DIR_READY = 3'd2,
        CFG_BLOCK     = 3'd3,
        CFG_CLOSE     = 3'd4,
        CFG_REOPEN    = 3'd5,
        CFG_RESET_EXC = 3'd6,
        CFG_MIN_HOLD  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ENTRY_READY     = 2'd0,
        ENTRY_EXCEPTION = 2'd1,
        ENTRY_DIRECTION = 2'd2,
        ENTRY_BLOCK     = 2'd3
    } t_entry;

    localparam int unsigned CTL_RESET_BIT = 7;
    localparam int unsigned CTL_IEN_BIT   = 6;
    localparam int unsigned CTL_DNIEN_BIT = 5;
    localparam logic [BYTE_W-1:0] STATUS_BASE = 8'hE7;

    typedef struct packed {
        logic [TIME_W-1:0] cmd_exec;
        logic [TIME_W-1:0] exc_ready;
        logic [TIME_W-1:0] dir_ready;
        logic [TIME_W-1:0] block;
        logic [TIME_W-1:0] close;
        logic [TIME_W-1:0] reopen;
        logic [TIME_W-1:0] reset_exc;
        logic [TIME_W-1:0] min_hold;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        cmd_exec:  32'd500000,
        exc_ready: 32'd10,
        dir_ready: 32'd650,
        block:     32'd5689,
        close:     32'd1,
        reopen:    32'd1,
        reset_exc: 32'd1000,
        min_hold:  32'd25
    };

    typedef struct packed {
        t_action           action;
        logic              flag_value;
        logic [TIME_W-1:0] time_value;
        logic [BYTE_W-1:0] write_value;
        logic [REG_W-1:0]  reg_index;
    } t_item;

    typedef struct packed {
        logic              busy_res;
        logic              irq_line;
        logic [BYTE_W-1:0] read_data;
    } t_result;

    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] control_byte;
        logic              ready;
        logic              exc;
        logic              dir;
        logic              done;
        logic              dma_busy;
        logic              executing;
        t_entry            entry_kind;
        logic [TIME_W-1:0] ready_deadline;
        logic              closing;
        logic [TIME_W-1:0] close_deadline;
        logic              reopening;
        logic [TIME_W-1:0] reopen_deadline;
        logic              arming;
        logic              pending;
        logic [TIME_W-1:0] exc_deadline;
        logic              hold_stamp_due;
        logic              hold_stamped;
        logic [TIME_W-1:0] hold_start;
    } t_state;

    function automatic t_state state_reset();
        t_state s;
        s      = '0;
        s.done = 1'b1;
        return s;
    endfunction

endpackage

>>> design/tchi_core.sv
// Controller state, configuration registers and per-transfer next-state logic.
module tchi_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  tchi_pkg::t_item              i_item,
    input  logic                         i_cfg_we,
    input  logic [tchi_pkg::CFG_W-1:0]   i_cfg_index,
    input  logic [tchi_pkg::TIME_W-1:0]  i_cfg_data,
    output tchi_pkg::t_result            o_result
);
    import tchi_pkg::*;

    t_cfg   r_cfg;
    t_state r_st;
    t_state n_st;

    logic              held;
    logic              wide;
    logic              int_flag;
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] rd;

    assign held = r_st.control_byte[CTL_RESET_BIT];
    assign wide = r_st.hold_stamped &&
                  ((r_st.time_now - r_st.hold_start) > r_cfg.min_hold);

    always_comb begin
        n_st = r_st;
        case (i_item.action)
            ACT_WRITE: begin
                unique case (t_reg'(i_item.reg_index))
                    REG_DATA: begin
                        n_st.data_byte = i_item.write_value;
                    end
                    REG_CTRL: begin
                        if (i_item.write_value[CTL_RESET_BIT]) begin
                            n_st = state_reset();
                            if (held) begin
                                n_st.hold_stamp_due = r_st.hold_stamp_due;
                                n_st.hold_stamped   = r_st.hold_stamped;
                                n_st.hold_start     = r_st.hold_start;
                            end else begin
                                n_st.hold_stamp_due = 1'b1;
                            end
                        end else if (held) begin
                            n_st.hold_stamp_due = 1'b0;
                            n_st.hold_stamped   = 1'b0;
                            if (wide) begin
                                n_st.exc    = 1'b0;
                                n_st.arming = 1'b1;
                            end
                        end
                        n_st.control_byte = i_item.write_value;
                    end
                    REG_DMA_GO: begin
                        n_st.dma_busy = 1'b1;
                        n_st.done     = 1'b0;
                    end
                    REG_DMA_RST: begin
                        n_st = state_reset();
                        if (held && wide) n_st.arming = 1'b1;
                    end
                    default: ;
                endcase
            end
            ACT_ADVANCE: begin
                if (i_item.time_value > r_st.time_now) n_st.time_now = i_item.time_value;
                if (r_st.hold_stamp_due) begin
                    n_st.hold_stamp_due = 1'b0;
                    n_st.hold_stamped   = 1'b1;
                    n_st.hold_start     = n_st.time_now;
                end
                if (r_st.arming) begin
                    n_st.arming       = 1'b0;
                    n_st.pending      = 1'b1;
                    n_st.exc_deadline = n_st.time_now + r_cfg.reset_exc;
                end else if (r_st.pending && n_st.time_now >= r_st.exc_deadline) begin
                    n_st.pending = 1'b0;
                    n_st.exc     = 1'b1;
                end
                if (r_st.executing && n_st.time_now >= r_st.ready_deadline) begin
                    n_st.exc = 1'b0;
                    if (r_st.entry_kind == ENTRY_DIRECTION) n_st.dir = 1'b0;
                    n_st.ready     = 1'b1;
                    n_st.executing = 1'b0;
                end
                if (r_st.closing && n_st.time_now >= r_st.close_deadline) begin
                    n_st.closing = 1'b0;
                    n_st.ready   = 1'b0;
                end
                if (r_st.reopening && n_st.time_now >= r_st.reopen_deadline) begin
                    n_st.reopening = 1'b0;
                    if (!n_st.exc) n_st.ready = 1'b1;
                end
            end
            ACT_CMD_ACC: begin
                if (r_st.exc) begin
                    n_st.entry_kind     = ENTRY_EXCEPTION;
                    n_st.ready_deadline = r_st.time_now + r_cfg.exc_ready;
                end else if (r_st.dir) begin
                    n_st.entry_kind     = ENTRY_DIRECTION;
                    n_st.ready_deadline = r_st.time_now + r_cfg.dir_ready;
                end else begin
                    n_st.entry_kind     = ENTRY_READY;
                    n_st.ready_deadline = r_st.time_now + r_cfg.cmd_exec;
                end
                n_st.ready     = 1'b0;
                n_st.executing = 1'b1;
                n_st.closing   = 1'b0;
                n_st.reopening = 1'b0;
            end
            ACT_BYTE_TKN: begin
                n_st.ready     = 1'b0;
                n_st.closing   = 1'b0;
                n_st.reopening = 1'b0;
            end
            ACT_REQ_REL: begin
                if (r_st.ready) begin
                    n_st.closing         = 1'b1;
                    n_st.close_deadline  = r_st.time_now + r_cfg.close;
                    n_st.reopen_deadline = r_st.time_now + r_cfg.close + r_cfg.reopen;
                end else begin
                    n_st.closing         = 1'b0;
                    n_st.reopen_deadline = r_st.time_now + r_cfg.reopen;
                end
                n_st.reopening = 1'b1;
            end
            ACT_BLOCK: begin
                n_st.entry_kind     = ENTRY_BLOCK;
                n_st.ready          = 1'b0;
                n_st.executing      = 1'b1;
                n_st.ready_deadline = r_st.time_now + r_cfg.block;
            end
            ACT_DMA_TC: begin
                n_st.dma_busy = 1'b0;
                n_st.done     = 1'b1;
            end
            ACT_SET_EXC: begin
                n_st.exc = i_item.flag_value;
                if (i_item.flag_value) n_st.ready = 1'b0;
            end
            ACT_SET_DIR: begin
                n_st.dir = i_item.flag_value;
            end
            default: ;
        endcase
    end

    // Reads leave the state untouched, so status comes from the current state.
    assign int_flag = r_st.ready || r_st.exc ||
                      (r_st.done && r_st.control_byte[CTL_DNIEN_BIT]);

    always_comb begin
        status = STATUS_BASE;
        if (int_flag)    status[7] = 1'b0;
        if (r_st.ready)  status[6] = 1'b0;
        if (r_st.exc)    status[5] = 1'b0;
        if (r_st.done)   status[4] = 1'b1;
        if (r_st.dir)    status[3] = 1'b1;
    end

    always_comb begin
        rd = '0;
        if (i_item.action == ACT_READ) begin
            case (t_reg'(i_item.reg_index))
                REG_DATA: rd = r_st.data_byte;
                REG_CTRL: rd = status;
                default:  rd = '0;
            endcase
        end
    end

    assign o_result.read_data = rd;
    assign o_result.busy_res  = n_st.executing;
    assign o_result.irq_line  = n_st.control_byte[CTL_IEN_BIT] &&
                                (n_st.ready || n_st.exc ||
                                 (n_st.done && n_st.control_byte[CTL_DNIEN_BIT]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= state_reset();
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CMD_EXEC:  r_cfg.cmd_exec  <= i_cfg_data;
                CFG_EXC_READY: r_cfg.exc_ready <= i_cfg_data;
                CFG_DIR_READY: r_cfg.dir_ready <= i_cfg_data;
                CFG_BLOCK:     r_cfg.block     <= i_cfg_data;
                CFG_CLOSE:     r_cfg.close     <= i_cfg_data;
                CFG_REOPEN:    r_cfg.reopen    <= i_cfg_data;
                CFG_RESET_EXC: r_cfg.reset_exc <= i_cfg_data;
                CFG_MIN_HOLD:  r_cfg.min_hold  <= i_cfg_data;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_dma_rst_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.action == ACT_WRITE && i_item.reg_index == REG_DMA_RST)
        |=> (!r_st.executing && r_st.done && r_st.time_now == '0))
        else $error("DMA reset did not return the controller to reset state");
    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.action == ACT_CMD_ACC) |=> (r_st.executing && !r_st.ready))
        else $error("accepted command did not start execution");
    a_dma_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.action == ACT_WRITE && i_item.reg_index == REG_DMA_GO)
        |=> (r_st.dma_busy && !r_st.done))
        else $error("DMA go did not mark DMA busy");
    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_item.action == ACT_ADVANCE) |=> (r_st.time_now >= $past(r_st.time_now)))
        else $error("time went backwards on an advance");
`endif

endmodule

>>> design/tape_controller_host_interface.sv
// Top level: stream ports, input register, controller core and result register.
// Host side of a QIC-02 style tape controller. Each input transfer carries one
// host action (register read/write, time advance or drive handshake event) and
// produces exactly one result transfer holding the byte read, the IEN-gated
// interrupt line and the busy flag. One transfer is taken every clock cycle
// unless the result side holds it back; each result passes through the input
// register, then the state update feeding the result register. Back-pressure
// on the result side stalls the input register only when the result register
// is still full. The user is to write the timing registers through the
// configuration port while the stream is idle; the block does not enforce it.
module tape_controller_host_interface (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // reg_index[1:0], write_value[9:2], time_value[41:10], flag_value[42], zeros
    input  logic [tchi_pkg::IN_DW-1:0]    i_s_axis_tdata,
    // action[3:0]
    input  logic [tchi_pkg::IN_UW-1:0]    i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // read_data[7:0], irq_line[8], busy_res[9], zeros
    output logic [tchi_pkg::OUT_DW-1:0]   o_m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [tchi_pkg::CFG_W-1:0]    i_cfg_index,
    input  logic [tchi_pkg::TIME_W-1:0]   i_cfg_data
);
    import tchi_pkg::*;

    localparam int unsigned ITEM_DW = $bits(t_item) - IN_UW;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    logic    adv;
    logic    in_take;

    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= t_item'({i_s_axis_tuser, i_s_axis_tdata[ITEM_DW-1:0]});
        end
    end

    tchi_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_item      (r_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DW - $bits(t_result)){1'b0}}, r_out};

endmodule

>>> verif/testbench.sv
// Self-checking stream testbench for the tape controller host interface.
module testbench;
    import tchi_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [BYTE_W-1:0] CTL_RESET_MASK = 8'h01 << CTL_RESET_BIT;

    typedef struct packed {
        logic [3:0]        action;
        logic              flag_value;
        logic [TIME_W-1:0] time_value;
        logic [BYTE_W-1:0] write_value;
        logic [REG_W-1:0]  reg_index;
    } t_host_action;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] rdy_dl;
        logic [TIME_W-1:0] close_dl;
        logic [TIME_W-1:0] reopen_dl;
        logic [TIME_W-1:0] exc_dl;
        logic [TIME_W-1:0] hold_start;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] ctrl;
        logic              ready;
        logic              exc;
        logic              dir;
        logic              done;
        logic              dma;
        logic              exec;
        logic              closing;
        logic              reopening;
        logic              arming;
        logic              pending;
        logic              dating;
        logic              dated;
        t_entry            entry;
    } t_drive_state;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [IN_DW-1:0]    i_s_axis_tdata = '0;
    logic [IN_UW-1:0]    i_s_axis_tuser = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [OUT_DW-1:0]   o_m_axis_tdata;
    logic                i_cfg_we = 1'b0;
    logic [CFG_W-1:0]    i_cfg_index = '0;
    logic [TIME_W-1:0]   i_cfg_data = '0;

    tape_controller_host_interface u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    t_drive_state   drive_st;
    logic [TIME_W-1:0] timing [0:7];
    t_host_action   pending_actions [$];
    t_result        expected_replies [$];
    t_host_action   next_action;
    t_result        got_reply;
    t_result        want_reply;
    logic [TIME_W-1:0] gen_time;
    int unsigned    phase_count;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    int unsigned    fail_count;
    int unsigned    cycle_count;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor
    function automatic t_drive_state clean_state();
        t_drive_state s;
        s       = '0;
        s.done  = 1'b1;
        s.entry = ENTRY_READY;
        return s;
    endfunction

    function automatic logic int_pending();
        return drive_st.ready || drive_st.exc || (drive_st.done && drive_st.ctrl[CTL_DNIEN_BIT]);
    endfunction

    function automatic logic hold_wide();
        logic [TIME_W-1:0] width;
        width = drive_st.now - drive_st.hold_start;
        return drive_st.dated && (width > timing[CFG_MIN_HOLD]);
    endfunction

    function automatic void reg_write(logic [REG_W-1:0] r, logic [BYTE_W-1:0] v);
        logic              held;
        logic              keep_dating;
        logic              keep_dated;
        logic              wide;
        logic [TIME_W-1:0] since;
        held = drive_st.ctrl[CTL_RESET_BIT];
        case (r)
            REG_DATA: begin
                drive_st.data = v;
            end
            REG_CTRL: begin
                if (v[CTL_RESET_BIT]) begin
                    keep_dating = held && drive_st.dating;
                    keep_dated  = held && drive_st.dated;
                    since       = held ? drive_st.hold_start : '0;
                    drive_st      = clean_state();
                    drive_st.ctrl = v;
                    if (held) begin
                        drive_st.dating     = keep_dating;
                        drive_st.dated      = keep_dated;
                        drive_st.hold_start = since;
                    end else begin
                        drive_st.dating = 1'b1;
                    end
                end else begin
                    drive_st.ctrl = v;
                    if (held) begin
                        wide = hold_wide();
                        drive_st.dating = 1'b0;
                        drive_st.dated  = 1'b0;
                        if (wide) begin
                            drive_st.exc    = 1'b0;
                            drive_st.arming = 1'b1;
                        end
                    end
                end
            end
            REG_DMA_GO: begin
                drive_st.dma  = 1'b1;
                drive_st.done = 1'b0;
            end
            default: begin
                wide = held && hold_wide();
                drive_st = clean_state();
                if (wide)
                    drive_st.arming = 1'b1;
            end
        endcase
    endfunction

    function automatic void time_advance(logic [TIME_W-1:0] t);
        if (t > drive_st.now)
            drive_st.now = t;
        if (drive_st.dating) begin
            drive_st.dating     = 1'b0;
            drive_st.dated      = 1'b1;
            drive_st.hold_start = drive_st.now;
        end
        if (drive_st.arming) begin
            drive_st.arming  = 1'b0;
            drive_st.pending = 1'b1;
            drive_st.exc_dl  = drive_st.now + timing[CFG_RESET_EXC];
        end else if (drive_st.pending && drive_st.now >= drive_st.exc_dl) begin
            drive_st.pending = 1'b0;
            drive_st.exc     = 1'b1;
        end
        if (drive_st.exec && drive_st.now >= drive_st.rdy_dl) begin
            drive_st.exc = 1'b0;
            if (drive_st.entry == ENTRY_DIRECTION)
                drive_st.dir = 1'b0;
            drive_st.ready = 1'b1;
            drive_st.exec  = 1'b0;
        end
        if (drive_st.closing && drive_st.now >= drive_st.close_dl) begin
            drive_st.closing = 1'b0;
            drive_st.ready   = 1'b0;
        end
        if (drive_st.reopening && drive_st.now >= drive_st.reopen_dl) begin
            drive_st.reopening = 1'b0;
            if (!drive_st.exc)
                drive_st.ready = 1'b1;
        end
    endfunction

    function automatic t_result host_step(t_host_action a);
        t_result res;
        logic [BYTE_W-1:0] st;
        res = '0;
        case (a.action)
            ACT_READ: begin
                if (a.reg_index == REG_DATA) begin
                    res.read_data = drive_st.data;
                end else if (a.reg_index == REG_CTRL) begin
                    st = STATUS_BASE;
                    if (int_pending()) st[7] = 1'b0;
                    if (drive_st.ready) st[6] = 1'b0;
                    if (drive_st.exc) st[5] = 1'b0;
                    if (drive_st.done) st[4] = 1'b1;
                    if (drive_st.dir) st[3] = 1'b1;
                    res.read_data = st;
                end
            end
            ACT_WRITE:   reg_write(a.reg_index, a.write_value);
            ACT_ADVANCE: time_advance(a.time_value);
            ACT_CMD_ACC: begin
                if (drive_st.exc) begin
                    drive_st.entry  = ENTRY_EXCEPTION;
                    drive_st.rdy_dl = drive_st.now + timing[CFG_EXC_READY];
                end else if (drive_st.dir) begin
                    drive_st.entry  = ENTRY_DIRECTION;
                    drive_st.rdy_dl = drive_st.now + timing[CFG_DIR_READY];
                end else begin
                    drive_st.entry  = ENTRY_READY;
                    drive_st.rdy_dl = drive_st.now + timing[CFG_CMD_EXEC];
                end
                drive_st.ready     = 1'b0;
                drive_st.exec      = 1'b1;
                drive_st.closing   = 1'b0;
                drive_st.reopening = 1'b0;
            end
            ACT_BYTE_TKN: begin
                drive_st.ready     = 1'b0;
                drive_st.closing   = 1'b0;
                drive_st.reopening = 1'b0;
            end
            ACT_REQ_REL: begin
                if (drive_st.ready) begin
                    drive_st.closing   = 1'b1;
                    drive_st.close_dl  = drive_st.now + timing[CFG_CLOSE];
                    drive_st.reopen_dl = drive_st.close_dl + timing[CFG_REOPEN];
                end else begin
                    drive_st.closing   = 1'b0;
                    drive_st.reopen_dl = drive_st.now + timing[CFG_REOPEN];
                end
                drive_st.reopening = 1'b1;
            end
            ACT_BLOCK: begin
                drive_st.entry  = ENTRY_BLOCK;
                drive_st.ready  = 1'b0;
                drive_st.exec   = 1'b1;
                drive_st.rdy_dl = drive_st.now + timing[CFG_BLOCK];
            end
            ACT_DMA_TC: begin
                drive_st.dma  = 1'b0;
                drive_st.done = 1'b1;
            end
            ACT_SET_EXC: begin
                drive_st.exc = a.flag_value;
                if (a.flag_value)
                    drive_st.ready = 1'b0;
            end
            ACT_SET_DIR: drive_st.dir = a.flag_value;
            default: ;
        endcase
        res.irq_line = drive_st.ctrl[CTL_IEN_BIT] && int_pending();
        res.busy_res = drive_st.exec;
        return res;
    endfunction

    // ------------------------------------------------------------------- driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_replies.push_back(host_step({i_s_axis_tuser, i_s_axis_tdata[42],
                    i_s_axis_tdata[41:10], i_s_axis_tdata[9:2], i_s_axis_tdata[1:0]}));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_actions.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_action = pending_actions.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser  <= next_action.action;
                    i_s_axis_tdata  <= {5'b0, next_action.flag_value, next_action.time_value,
                                        next_action.write_value, next_action.reg_index};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------ monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_reply = o_m_axis_tdata[9:0];
                if (expected_replies.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected transfer: rd=%02h irq=%0b busy=%0b",
                                 got_reply.read_data, got_reply.irq_line, got_reply.busy_res);
                    fail_count++;
                end else begin
                    want_reply = expected_replies.pop_front();
                    if (got_reply.read_data !== want_reply.read_data ||
                        got_reply.irq_line !== want_reply.irq_line ||
                        got_reply.busy_res !== want_reply.busy_res) begin
                        if (fail_count < 10)
                            $display({"mismatch: expected rd=%02h irq=%0b busy=%0b,",
                                      " got rd=%02h irq=%0b busy=%0b"},
                                     want_reply.read_data, want_reply.irq_line,
                                     want_reply.busy_res, got_reply.read_data,
                                     got_reply.irq_line, got_reply.busy_res);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic t_host_action rand_action();
        t_host_action a;
        a.action      = 4'($urandom_range(15));
        a.reg_index   = 2'($urandom_range(3));
        a.write_value = 8'($urandom_range(255));
        a.time_value  = $urandom();
        a.flag_value  = 1'($urandom_range(1));
        return a;
    endfunction

    task automatic push_action(t_host_action a);
        if (a.action == ACT_ADVANCE && a.time_value > gen_time)
            gen_time = a.time_value;
        if (a.action == ACT_WRITE && (a.reg_index == REG_DMA_RST ||
            (a.reg_index == REG_CTRL && a.write_value[CTL_RESET_BIT])))
            gen_time = '0;
        if (a.action <= ACT_SET_DIR)
            phase_count++;
        pending_actions.push_back(a);
    endtask

    task automatic add_op(logic [3:0] act);
        t_host_action a;
        a = rand_action();
        a.action = act;
        push_action(a);
    endtask

    task automatic add_flag(logic [3:0] act, logic f);
        t_host_action a;
        a = rand_action();
        a.action     = act;
        a.flag_value = f;
        push_action(a);
    endtask

    task automatic add_read(logic [REG_W-1:0] r);
        t_host_action a;
        a = rand_action();
        a.action    = ACT_READ;
        a.reg_index = r;
        push_action(a);
    endtask

    task automatic add_write(logic [REG_W-1:0] r, logic [BYTE_W-1:0] v);
        t_host_action a;
        a = rand_action();
        a.action      = ACT_WRITE;
        a.reg_index   = r;
        a.write_value = v;
        push_action(a);
    endtask

    task automatic add_advance(logic [TIME_W-1:0] t);
        t_host_action a;
        a = rand_action();
        a.action     = ACT_ADVANCE;
        a.time_value = t;
        push_action(a);
    endtask

    // times around a deadline, with one in four somewhere up to it
    function automatic logic [TIME_W-1:0] near_time(logic [TIME_W-1:0] base,
                                                    logic [TIME_W-1:0] span);
        logic [TIME_W-1:0] pick;
        case ($urandom_range(3))
            0:       pick = base + span - 32'd1;
            1:       pick = base + span;
            2:       pick = base + span + 32'd1;
            default: pick = base + $urandom_range(span);
        endcase
        return pick;
    endfunction

    task automatic add_burst();
        logic [TIME_W-1:0] base;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] t0;
        case ($urandom_range(9))
            0, 1: begin
                if ($urandom_range(3) == 0) add_op(ACT_SET_DIR);
                if ($urandom_range(3) == 0) add_op(ACT_SET_EXC);
                case ($urandom_range(3))
                    0:       span = timing[CFG_EXC_READY];
                    1:       span = timing[CFG_DIR_READY];
                    2:       span = timing[CFG_BLOCK];
                    default: span = timing[CFG_CMD_EXEC];
                endcase
                base = gen_time;
                if ($urandom_range(3) == 0) add_op(ACT_BLOCK);
                else add_op(ACT_CMD_ACC);
                repeat ($urandom_range(1, 4)) begin
                    add_advance(near_time(base, span));
                    add_read(REG_CTRL);
                end
            end
            2: begin
                base = gen_time;
                add_op(ACT_REQ_REL);
                if ($urandom_range(3) == 0) add_op(ACT_BYTE_TKN);
                add_advance(near_time(base, timing[CFG_CLOSE]));
                add_read(REG_CTRL);
                add_advance(near_time(base, timing[CFG_CLOSE] + timing[CFG_REOPEN]));
                add_read(REG_CTRL);
            end
            3: begin
                // reset pulse: hold, date it, release around the minimum width
                add_write(REG_CTRL, CTL_RESET_MASK | 8'($urandom_range(127)));
                t0 = $urandom_range(1000);
                add_advance(t0);
                add_advance(near_time(t0, timing[CFG_MIN_HOLD] + 32'd1));
                if ($urandom_range(1) == 0) add_write(REG_CTRL, 8'($urandom_range(127)));
                else add_write(REG_DMA_RST, 8'($urandom_range(255)));
                add_advance(gen_time + 32'($urandom_range(50)));
                add_advance(near_time(gen_time, timing[CFG_RESET_EXC]));
                add_read(REG_CTRL);
            end
            4: begin
                add_write(REG_CTRL, 8'($urandom_range(127)));
                add_read(REG_CTRL);
            end
            5: begin
                add_write(REG_DMA_GO, 8'($urandom_range(255)));
                add_read(REG_CTRL);
                add_op(ACT_DMA_TC);
                add_read(REG_CTRL);
            end
            6: begin
                case ($urandom_range(2))
                    0:       add_op(ACT_SET_EXC);
                    1:       add_op(ACT_SET_DIR);
                    default: add_op(ACT_BYTE_TKN);
                endcase
                add_read(REG_CTRL);
            end
            7: begin
                add_write(REG_DATA, 8'($urandom_range(255)));
                add_read(2'($urandom_range(3)));
            end
            8: begin
                if ($urandom_range(1) == 0) add_advance(gen_time - 32'($urandom_range(100)));
                else add_advance($urandom());
                add_read(2'($urandom_range(3)));
            end
            default: begin
                repeat ($urandom_range(1, 4)) push_action(rand_action());
            end
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_actions.size() != 0 || i_s_axis_tvalid || expected_replies.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timing(t_cfg_idx idx, logic [TIME_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        timing[idx] = val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random(int unsigned n);
        phase_count = 0;
        while (phase_count < n)
            add_burst();
        wait_idle();
    endtask

    initial begin
        fail_count    = 0;
        cycle_count   = 0;
        gen_time      = '0;
        send_idle_pct = 34;
        recv_idle_pct = 45;
        drive_st      = clean_state();
        timing[CFG_CMD_EXEC]  = CFG_RESET.cmd_exec;
        timing[CFG_EXC_READY] = CFG_RESET.exc_ready;
        timing[CFG_DIR_READY] = CFG_RESET.dir_ready;
        timing[CFG_BLOCK]     = CFG_RESET.block;
        timing[CFG_CLOSE]     = CFG_RESET.close;
        timing[CFG_REOPEN]    = CFG_RESET.reopen;
        timing[CFG_RESET_EXC] = CFG_RESET.reset_exc;
        timing[CFG_MIN_HOLD]  = CFG_RESET.min_hold;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset values, every register and operation, flag edges
        add_read(REG_DATA);
        add_read(REG_CTRL);
        add_read(REG_DMA_GO);
        add_read(REG_DMA_RST);
        add_write(REG_DATA, 8'hFF);
        add_write(REG_CTRL, 8'h60);
        add_read(REG_CTRL);
        add_write(REG_DMA_GO, 8'hAB);
        add_op(ACT_DMA_TC);
        add_flag(ACT_SET_EXC, 1'b1);
        add_flag(ACT_SET_EXC, 1'b0);
        add_flag(ACT_SET_DIR, 1'b1);
        add_op(ACT_CMD_ACC);
        add_advance(32'hFFFF_FFFF);
        add_advance(32'h0);
        add_read(REG_CTRL);
        add_op(ACT_BYTE_TKN);
        add_op(ACT_REQ_REL);
        add_op(ACT_BLOCK);
        add_op(4'hF);
        add_write(REG_CTRL, CTL_RESET_MASK);
        add_advance(32'd5);
        add_advance(32'd100);
        add_write(REG_DMA_RST, 8'h00);
        add_advance(32'd3);
        add_advance(32'd2000);
        add_read(REG_CTRL);
        wait_idle();

        for (int k = 0; k < 8; k++)
            set_timing(t_cfg_idx'(k), '0);
        run_random(300);

        send_idle_pct = 45;
        recv_idle_pct = 34;
        for (int k = 0; k < 8; k++)
            set_timing(t_cfg_idx'(k), 32'hFFFF_FFFF);
        run_random(300);

        set_timing(CFG_CMD_EXEC, $urandom_range(600000));
        set_timing(CFG_EXC_READY, $urandom_range(40));
        set_timing(CFG_DIR_READY, $urandom_range(2000));
        set_timing(CFG_BLOCK, $urandom_range(8000));
        set_timing(CFG_CLOSE, $urandom_range(5));
        set_timing(CFG_REOPEN, $urandom_range(5));
        set_timing(CFG_RESET_EXC, $urandom_range(3000));
        set_timing(CFG_MIN_HOLD, $urandom_range(100));
        run_random(275);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timing(CFG_CMD_EXEC, CFG_RESET.cmd_exec);
        set_timing(CFG_EXC_READY, CFG_RESET.exc_ready);
        set_timing(CFG_DIR_READY, CFG_RESET.dir_ready);
        set_timing(CFG_BLOCK, CFG_RESET.block);
        set_timing(CFG_CLOSE, CFG_RESET.close);
        set_timing(CFG_REOPEN, CFG_RESET.reopen);
        set_timing(CFG_RESET_EXC, CFG_RESET.reset_exc);
        set_timing(CFG_MIN_HOLD, CFG_RESET.min_hold);
        run_random(275);

        repeat (8) @(posedge i_clk);
        if (expected_replies.size() != 0)
            fail_count++;
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
